>>> src/md5_message_digest_defines.svh
// ---------------------------------------------------------------------------
// md5_message_digest_defines.svh
// Shared assertion macros for the MD5 digest block. Each macro samples on
// clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication
`define MD5_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/md5_pkg.sv
// ---------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 digest block.
// ---------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  // Standard MD5 initial chaining value
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte appended after the message
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Input transaction payload
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_item_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [31:0] word;       // masked word, pad byte already merged on a short last word
    logic        is_last;
    logic        extra_pad;  // last word was full: pad byte goes in a word of its own
    logic [5:0]  add_bits;   // message bits carried by this word
  } q_entry_t;

  // Additive round constants
  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Per-round rotate amount, by stage and round within a group of four
  function automatic logic [4:0] md5_rot(input logic [1:0] stage, input logic [1:0] j);
    logic [4:0] s;
    case ({stage, j})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> src/md5_front.sv
// ---------------------------------------------------------------------------
// md5_front
// Accepts input transactions, normalizes the byte count, masks and pads a
// short last word, and queues the classified words for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "md5_message_digest_defines.svh"

module md5_front #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire md5_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output md5_pkg::q_entry_t      q_data
);
  import md5_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         queue_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [2:0]  n_bytes;
  logic [31:0] keep_mask;
  q_entry_t    entry;
  logic        push, pop;

  // Classify the incoming word
  always_comb begin
    n_bytes = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    case (n_bytes)
      3'd0:    keep_mask = 32'h0000_0000;
      3'd1:    keep_mask = 32'h0000_00ff;
      3'd2:    keep_mask = 32'h0000_ffff;
      3'd3:    keep_mask = 32'h00ff_ffff;
      default: keep_mask = 32'hffff_ffff;
    endcase
    entry.is_last = in_data.last_word;
    if (!in_data.last_word) begin
      entry.word      = in_data.data_word;
      entry.extra_pad = 1'b0;
      entry.add_bits  = 6'd32;
    end else if (n_bytes == 3'd4) begin
      entry.word      = in_data.data_word;
      entry.extra_pad = 1'b1;
      entry.add_bits  = 6'd32;
    end else begin
      entry.word      = (in_data.data_word & keep_mask) |
                        (32'(PAD_BYTE) << {n_bytes[1:0], 3'b000});
      entry.extra_pad = 1'b0;
      entry.add_bits  = {n_bytes, 3'b000};
    end
  end

  // Queue control
  assign in_ready = (cnt_r != CNT_W'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = queue_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  // Checks
  `MD5_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count above depth")
  `MD5_ASSERT_NEXT(a_cnt_push, (push && !pop), cnt_r == CNT_W'($past(cnt_r) + 1'b1), "push lost")

endmodule

`default_nettype wire

>>> src/md5_core.sv
// ---------------------------------------------------------------------------
// md5_core
// Back end: fills the 16-word block buffer, generates padding and length,
// runs the 64 MD5 rounds one per cycle and delivers the digest.
// ---------------------------------------------------------------------------
`default_nettype none
`include "md5_message_digest_defines.svh"

module md5_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire md5_pkg::q_entry_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output md5_pkg::out_item_t     out_data
);
  import md5_pkg::*;

  localparam logic [3:0] LAST_POS   = 4'd15;
  localparam logic [3:0] LEN_LO_POS = 4'd14;
  localparam logic [5:0] LAST_RND   = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0][31:0] chain_r, chain_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [63:0]      bits_r, bits_nxt;
  logic             pad_r, pad_nxt;
  logic             need80_r, need80_nxt;
  logic             lo_done_r, lo_done_nxt;
  logic             finish_r, finish_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  logic [31:0]      wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt, wd_r, wd_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [31:0] blk_r [16];
  logic        blk_we;
  logic [31:0] blk_wdata;

  logic        start_round, out_load;
  logic [1:0]  stage;
  logic [3:0]  i4, g_idx;
  logic [31:0] f_val, sum;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Round function for the current round
  always_comb begin
    stage = rnd_r[5:4];
    i4    = rnd_r[3:0];
    case (stage)
      2'd0: begin
        f_val = (wb_r & wc_r) | (~wb_r & wd_r);
        g_idx = i4;
      end
      2'd1: begin
        f_val = (wd_r & wb_r) | (~wd_r & wc_r);
        g_idx = 4'(i4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f_val = wb_r ^ wc_r ^ wd_r;
        g_idx = 4'(i4 * 4'd3 + 4'd5);
      end
      default: begin
        f_val = wc_r ^ (wb_r | ~wd_r);
        g_idx = 4'(i4 * 4'd7);
      end
    endcase
    sum = wa_r + f_val + md5_k(rnd_r) + blk_r[g_idx];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    pos_nxt       = pos_r;
    bits_nxt      = bits_r;
    pad_nxt       = pad_r;
    need80_nxt    = need80_r;
    lo_done_nxt   = lo_done_r;
    finish_nxt    = finish_r;
    rnd_nxt       = rnd_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    wc_nxt        = wc_r;
    wd_nxt        = wd_r;
    out_nxt       = out_r;
    blk_we        = 1'b0;
    blk_wdata     = '0;
    start_round   = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          blk_we    = 1'b1;
          blk_wdata = q_data.word;
          pos_nxt   = pos_r + 1'b1;
          bits_nxt  = bits_r + 64'(q_data.add_bits);
          if (q_data.is_last) begin
            pad_nxt     = 1'b1;
            need80_nxt  = q_data.extra_pad;
            lo_done_nxt = 1'b0;
            finish_nxt  = 1'b0;
          end
          if (pos_r == LAST_POS) begin
            start_round = 1'b1;
          end else if (q_data.is_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // pad byte first, then zeros, length low at slot 14, high at slot 15
        blk_we = 1'b1;
        if (need80_r) begin
          blk_wdata  = 32'(PAD_BYTE);
          need80_nxt = 1'b0;
        end else if (pos_r == LEN_LO_POS && !lo_done_r) begin
          blk_wdata   = bits_r[31:0];
          lo_done_nxt = 1'b1;
        end else if (pos_r == LAST_POS && lo_done_r) begin
          blk_wdata  = bits_r[63:32];
          finish_nxt = 1'b1;
        end
        pos_nxt = pos_r + 1'b1;
        if (pos_r == LAST_POS) begin
          start_round = 1'b1;
        end
      end
      ST_ROUND: begin
        wa_nxt  = wd_r;
        wd_nxt  = wc_r;
        wc_nxt  = wb_r;
        wb_nxt  = wb_r + rotl32(sum, md5_rot(stage, rnd_r[1:0]));
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + wa_r;
        chain_nxt[1] = chain_r[1] + wb_r;
        chain_nxt[2] = chain_r[2] + wc_r;
        chain_nxt[3] = chain_r[3] + wd_r;
        if (finish_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load            = 1'b1;
          out_nxt.digest_low  = {chain_r[1], chain_r[0]};
          out_nxt.digest_high = {chain_r[3], chain_r[2]};
          chain_nxt           = {IV_D, IV_C, IV_B, IV_A};
          pos_nxt             = '0;
          bits_nxt            = '0;
          pad_nxt             = 1'b0;
          need80_nxt          = 1'b0;
          lo_done_nxt         = 1'b0;
          finish_nxt          = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Block complete: load working words from the chain
    if (start_round) begin
      state_nxt = ST_ROUND;
      rnd_nxt   = '0;
      wa_nxt    = chain_r[0];
      wb_nxt    = chain_r[1];
      wc_nxt    = chain_r[2];
      wd_nxt    = chain_r[3];
    end

    // Output register
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chain_r     <= {IV_D, IV_C, IV_B, IV_A};
      pos_r       <= '0;
      bits_r      <= '0;
      pad_r       <= 1'b0;
      need80_r    <= 1'b0;
      lo_done_r   <= 1'b0;
      finish_r    <= 1'b0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      pos_r       <= pos_nxt;
      bits_r      <= bits_nxt;
      pad_r       <= pad_nxt;
      need80_r    <= need80_nxt;
      lo_done_r   <= lo_done_nxt;
      finish_r    <= finish_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wa_r  <= wa_nxt;
    wb_r  <= wb_nxt;
    wc_r  <= wc_nxt;
    wd_r  <= wd_nxt;
    out_r <= out_nxt;
  end

  // Block buffer, payload only
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_r[pos_r] <= blk_wdata;
    end
  end

  // Checks
  `MD5_ASSERT_NEXT(a_rounds_end, (state_r == ST_ROUND && rnd_r == LAST_RND), state_r == ST_ADD, "round count overrun")
  `MD5_ASSERT_IMPLY(a_finish_pos, (state_r == ST_ADD && finish_r), pos_r == 4'd0, "final block not aligned")
  `MD5_ASSERT_IMPLY(a_len_hi_slot, (state_r == ST_PAD && lo_done_r), pos_r == LAST_POS, "length high misplaced")
  `MD5_ASSERT_NEXT(a_emit_restart, (state_r == ST_EMIT && (!out_valid_r || out_ready)), (out_valid_r && pos_r == 4'd0 && bits_r == 64'd0), "no restart after digest")

endmodule

`default_nettype wire

>>> src/md5_message_digest.sv
// ---------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a message streamed as 32-bit little-endian words (first byte
// in bits 7:0). The last word carries 0 to 4 valid bytes and produces one
// result transaction with the 128-bit digest: A in digest_low[31:0], B in
// digest_low[63:32], C in digest_high[31:0], D in digest_high[63:32]; the
// engine then restarts from the MD5 initial value. A small input queue takes
// words while the single round unit is busy. Each word is written into the
// block buffer while the core is idle, and every 16th word starts the 64
// rounds and the fold into the chaining value. After the last word, padding
// and length are written one word per cycle, followed by one or two block
// compressions, and then the result register is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_message_digest #(
  parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire md5_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output md5_pkg::out_item_t     out_data
);
  import md5_pkg::*;

  logic     q_valid;
  logic     q_ready;
  q_entry_t q_data;

  // Front: classify and queue
  md5_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  // Back: buffer, padding, rounds, result
  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
